// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Types and constants for the multi-channel countdown timer unit.
// ----------------------------------------------------------------------------
package mct_pkg;

  // Table size and derived widths
  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_TIMERS);
  localparam int unsigned CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int unsigned MS_W       = 32;
  localparam int unsigned TIU_W      = 5;
  localparam logic [TIU_W-1:0] TIU_RESET = TIU_W'(16);

  // Request opcodes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  // Per-timer run state
  typedef enum logic [1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_EXPIRED = 2'd2
  } run_state_e;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EVAL = 2'd2,
    ST_DONE = 2'd3
  } ctl_state_e;

  // One memory word: reload period above remaining count
  typedef struct packed {
    logic [MS_W-1:0] reload;
    logic [MS_W-1:0] remaining;
  } timer_word_t;

endpackage

// File: hw/rtl/multi_channel_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_unit
// Table of sixteen one-shot / periodic countdown timers with tick scan.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i / in_stall_o; results leave on out_valid_o /
//   out_stall_i. A request is taken when valid is high and stall is low.
//   Start, stop and query give one result (last_o = 1) in the cycle after
//   they are taken. A tick walks slots 0 .. min(timers_in_use, 16)-1: a
//   stopped or expired slot is stepped over, a running slot is read from
//   memory in ST_SCAN, then counted down and written back in ST_EVAL, and
//   ST_DONE closes the scan. The count and reload words live in one
//   synchronous memory; run state and mode sit in flops. Each firing
//   timer gives one result; a tick with no firing gives one result with
//   fired_o = 0. The last result of a request has last_o = 1.
//   One request is in work at a time; in_stall_o is high during a tick scan
//   and while the output register holds an untaken result.
//   A stalled receiver freezes the output register and the scan waits at the
//   next firing timer if one is held. Reset stops all timers, clears all modes,
//   sets timers_in_use to 16 and needs no clearing pass. timers_in_use is
//   written over cfg_valid_i / cfg_ready_o while the unit is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_countdown_timer_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [mct_pkg::TIU_W-1:0] cfg_data_i,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [3:0]               timer_index_i,
  input  logic                     periodic_i,
  input  logic [31:0]              period_ms_i,
  input  logic [31:0]              delay_ms_i,
  input  logic [31:0]              elapsed_ms_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     fired_o,
  output logic [3:0]               fired_index_o,
  output logic                     is_running_o,
  output logic                     last_o
);

  localparam int unsigned IDX_W = mct_pkg::IDX_W;
  localparam int unsigned CNT_W = mct_pkg::CNT_W;
  localparam int unsigned MS_W  = mct_pkg::MS_W;

  // Control and status registers
  mct_pkg::ctl_state_e     state_q, state_d;
  logic [mct_pkg::TIU_W-1:0] tiu_q;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic [MS_W-1:0]         elapsed_q;
  logic                    elapsed_we;

  mct_pkg::run_state_e     run_state_q [mct_pkg::NUM_TIMERS];
  logic                    periodic_q  [mct_pkg::NUM_TIMERS];
  logic                    rs_we, pm_we;
  logic [IDX_W-1:0]        rs_waddr;
  mct_pkg::run_state_e     rs_wdata;

  // Output register
  logic                    out_valid_q;
  logic                    fired_q, running_q, last_q;
  logic [IDX_W-1:0]        fidx_q;
  logic                    out_load, out_free;
  logic                    ld_fired, ld_running, ld_last;
  logic [IDX_W-1:0]        ld_idx;

  // Count / reload memory
  mct_pkg::timer_word_t    mem [mct_pkg::NUM_TIMERS];
  mct_pkg::timer_word_t    rd_data_q, mem_wdata;
  logic                    mem_we, mem_rd_en;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;

  // Decode and scan datapath
  logic                    in_acc, idx_ok;
  logic [IDX_W-1:0]        req_idx, scan_idx;
  logic [CNT_W-1:0]        scan_lim;
  logic [MS_W-1:0]         sub_cnt;
  logic                    fire;
  mct_pkg::cmd_e           cmd;

  assign cmd         = mct_pkg::cmd_e'(cmd_i);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == mct_pkg::ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == mct_pkg::ST_IDLE);
  assign idx_ok      = 32'(timer_index_i) < mct_pkg::NUM_TIMERS;
  assign req_idx     = timer_index_i[IDX_W-1:0];
  assign scan_idx    = idx_q[IDX_W-1:0];

  // Slots scanned per tick, clamped to the table size
  assign scan_lim = (32'(tiu_q) > mct_pkg::NUM_TIMERS) ? CNT_W'(mct_pkg::NUM_TIMERS)
                                                      : CNT_W'(tiu_q);

  // Count-down step for the slot under evaluation
  always_comb begin
    sub_cnt = (rd_data_q.remaining >= elapsed_q) ? rd_data_q.remaining - elapsed_q
                                                 : rd_data_q.remaining;
    fire    = sub_cnt < elapsed_q;
  end

  // Sequencer: next state, memory and table writes, result loads
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    elapsed_we   = 1'b0;
    rs_we        = 1'b0;
    pm_we        = 1'b0;
    rs_waddr     = req_idx;
    rs_wdata     = mct_pkg::RS_STOPPED;
    mem_we       = 1'b0;
    mem_rd_en    = 1'b0;
    mem_waddr    = req_idx;
    mem_raddr    = scan_idx;
    mem_wdata    = '{reload: period_ms_i, remaining: period_ms_i + delay_ms_i};
    out_load     = 1'b0;
    ld_fired     = 1'b0;
    ld_idx       = '0;
    ld_running   = 1'b0;
    ld_last      = 1'b1;
    case (state_q)
      mct_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            mct_pkg::CMD_START: begin
              out_load = 1'b1;
              if (idx_ok) begin
                mem_we   = 1'b1;
                rs_we    = 1'b1;
                pm_we    = 1'b1;
                rs_wdata = mct_pkg::RS_RUNNING;
              end
            end
            mct_pkg::CMD_STOP: begin
              out_load = 1'b1;
              rs_we    = idx_ok;
            end
            mct_pkg::CMD_QUERY: begin
              out_load   = 1'b1;
              ld_running = idx_ok && (run_state_q[req_idx] == mct_pkg::RS_RUNNING);
            end
            mct_pkg::CMD_TICK: begin
              elapsed_we   = 1'b1;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = mct_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      // Walk slots; read memory only for running ones
      mct_pkg::ST_SCAN: begin
        if (idx_q >= scan_lim) begin
          state_d = mct_pkg::ST_DONE;
        end else if (run_state_q[scan_idx] == mct_pkg::RS_RUNNING) begin
          mem_rd_en = 1'b1;
          state_d   = mct_pkg::ST_EVAL;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      // Count down, write back; a new firing pushes out the held one
      mct_pkg::ST_EVAL: begin
        if (!(fire && pend_valid_q && !out_free)) begin
          mem_we    = 1'b1;
          mem_waddr = scan_idx;
          mem_wdata.reload    = rd_data_q.reload;
          mem_wdata.remaining = (fire && periodic_q[scan_idx]) ? rd_data_q.reload : sub_cnt;
          if (fire) begin
            if (!periodic_q[scan_idx]) begin
              rs_we    = 1'b1;
              rs_waddr = scan_idx;
              rs_wdata = mct_pkg::RS_EXPIRED;
            end
            if (pend_valid_q) begin
              out_load = 1'b1;
              ld_fired = 1'b1;
              ld_idx   = pend_idx_q;
              ld_last  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = scan_idx;
          end
          idx_d   = idx_q + CNT_W'(1);
          state_d = mct_pkg::ST_SCAN;
        end
      end
      // Final result of the tick
      mct_pkg::ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          ld_fired     = pend_valid_q;
          ld_idx       = pend_valid_q ? pend_idx_q : '0;
          pend_valid_d = 1'b0;
          state_d      = mct_pkg::ST_IDLE;
        end
      end
      default: state_d = mct_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mct_pkg::ST_IDLE;
      tiu_q        <= mct_pkg::TIU_RESET;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_load || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) begin
        tiu_q <= cfg_data_i;
      end
    end
  end

  // Run state and mode flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mct_pkg::NUM_TIMERS; i++) begin
        run_state_q[i] <= mct_pkg::RS_STOPPED;
        periodic_q[i]  <= 1'b0;
      end
    end else begin
      if (rs_we) begin
        run_state_q[rs_waddr] <= rs_wdata;
      end
      if (pm_we) begin
        periodic_q[req_idx] <= periodic_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (elapsed_we) begin
      elapsed_q <= elapsed_ms_i;
    end
    pend_idx_q <= pend_idx_d;
    if (out_load) begin
      fired_q   <= ld_fired;
      fidx_q    <= ld_idx;
      running_q <= ld_running;
      last_q    <= ld_last;
    end
  end

  // Count / reload memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fired_o       = fired_q;
  assign fired_index_o = 4'(fidx_q);
  assign is_running_o  = running_q;
  assign last_o        = last_q;

  // Assertions
  `ASSERT_NEVER(a_out_no_overwrite, out_load && out_valid_q && out_stall_i, "result overwritten")
  `ASSERT_NEVER(a_acc_only_idle, in_acc && (state_q != mct_pkg::ST_IDLE), "request taken mid-scan")
  `ASSERT_CLK(a_eval_from_scan, (state_q == mct_pkg::ST_EVAL) |-> ($past(state_q) == mct_pkg::ST_SCAN || $past(state_q) == mct_pkg::ST_EVAL), "eval without read")
  `ASSERT_CLK(a_pend_in_tick, pend_valid_q |-> (state_q != mct_pkg::ST_IDLE), "held firing outside tick")
  `ASSERT_CLK(a_done_to_idle, (state_q == mct_pkg::ST_DONE && out_load) |=> (state_q == mct_pkg::ST_IDLE), "tick did not close")

endmodule
